FILE: src/bmm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the button mouse mover.
// No dependencies; imported by bmm_dir, bmm_trig, the top level and the checker.
package bmm_pkg;

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_SLOW_LIMIT = 3'd0,
		REG_FAST_LIMIT = 3'd1,
		REG_SPEED_SLOW = 3'd2,
		REG_SPEED_MID  = 3'd3,
		REG_SPEED_FAST = 3'd4,
		REG_RADIUS     = 3'd5,
		REG_PHASE_STEP = 3'd6
	} cfg_reg_t;

	localparam logic [15:0] RST_SLOW_LIMIT = 16'd50;
	localparam logic [15:0] RST_FAST_LIMIT = 16'd150;
	localparam logic [6:0]  RST_SPEED_SLOW = 7'd2;
	localparam logic [6:0]  RST_SPEED_MID  = 7'd5;
	localparam logic [6:0]  RST_SPEED_FAST = 7'd10;
	localparam logic [6:0]  RST_RADIUS     = 7'd10;
	localparam logic [15:0] RST_PHASE_STEP = 16'd1043;

	// Stream payload layout
	localparam int IN_W  = 8;
	localparam int OUT_W = 24;

	// Fixed-point trig constants: one in Q32, and the fractional part of
	// 2*pi in Q32 (2*pi*2^32 = 6*2^32 + TWO_PI_FRAC)
	localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
	localparam logic [30:0] TWO_PI_FRAC = 31'd1216271633;

	// Horner chain: sine divisors 110, 72, 42, 20, 6, then cosine divisors
	// 132, 90, 56, 30, 12, 2. Each divide is an exact multiply by
	// ceil(2^(32+l)/k) followed by a right shift of 32+l, l = ceil(log2 k).
	localparam int TRIG_STEPS = 11;
	localparam logic [3:0] SIN_LAST = 4'd4;
	localparam logic [3:0] COS_LAST = 4'd10;

	localparam logic [32:0] CHAIN_M [TRIG_STEPS] = '{
		33'(((64'd1 << 39) + 64'd109) / 64'd110),
		33'(((64'd1 << 39) + 64'd71)  / 64'd72),
		33'(((64'd1 << 38) + 64'd41)  / 64'd42),
		33'(((64'd1 << 37) + 64'd19)  / 64'd20),
		33'(((64'd1 << 35) + 64'd5)   / 64'd6),
		33'(((64'd1 << 40) + 64'd131) / 64'd132),
		33'(((64'd1 << 39) + 64'd89)  / 64'd90),
		33'(((64'd1 << 38) + 64'd55)  / 64'd56),
		33'(((64'd1 << 37) + 64'd29)  / 64'd30),
		33'(((64'd1 << 36) + 64'd11)  / 64'd12),
		33'(((64'd1 << 33) + 64'd1)   / 64'd2)
	};

	localparam logic [3:0] CHAIN_L [TRIG_STEPS] = '{
		4'd7, 4'd7, 4'd6, 4'd5, 4'd3, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd1
	};

	// Top-level sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIR,
		ST_TRIG,
		ST_DONE
	} top_state_t;

	// Trig sequencer around the shared multiplier
	typedef enum logic [3:0] {
		TR_IDLE,
		TR_X_MUL,
		TR_X_GET,
		TR_S_MUL,
		TR_S_GET,
		TR_T_MUL,
		TR_D_MUL,
		TR_D_GET,
		TR_SIN_MUL,
		TR_SIN_GET,
		TR_SX_MUL,
		TR_SX_GET,
		TR_SY_MUL,
		TR_SY_GET,
		TR_DONE
	} trig_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} trig_sts_t;

endpackage

FILE: src/bmm_mul.sv
`timescale 1ns / 1ps
// Shared 33x33 unsigned multiplier with a registered product.
// Uses no package items; driven by the trig sequencer.
module bmm_mul (
	input  logic        clk,
	input  logic [32:0] op_a,
	input  logic [32:0] op_b,
	output logic [65:0] prod
);

	logic [65:0] prod_q;

	// Register the product every cycle; the sequencer reads it in the cycle after
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

FILE: src/bmm_dir.sv
`timescale 1ns / 1ps
// Direction-mode stepping: hold counters and speed selection per axis.
// Depends on bmm_pkg.
module bmm_dir
	import bmm_pkg::*;
#(
	parameter int HOLD_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              update,
	input  logic              up_btn,
	input  logic              down_btn,
	input  logic              left_btn,
	input  logic              right_btn,
	input  logic [15:0]       slow_limit,
	input  logic [15:0]       fast_limit,
	input  logic [6:0]        speed_slow,
	input  logic [6:0]        speed_mid,
	input  logic [6:0]        speed_fast,
	output logic signed [7:0] step_x,
	output logic signed [7:0] step_y
);

	localparam int CMP_W = (HOLD_BITS > 16) ? HOLD_BITS : 16;

	logic [HOLD_BITS-1:0] up_hold_q, down_hold_q, left_hold_q, right_hold_q;
	logic [HOLD_BITS-1:0] up_inc, down_inc, left_inc, right_inc;

	function automatic logic [HOLD_BITS-1:0] hold_inc(input logic [HOLD_BITS-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic logic [6:0] speed_sel(input logic [HOLD_BITS-1:0] c,
			input logic [15:0] lim_s, input logic [15:0] lim_f,
			input logic [6:0] sp_s, input logic [6:0] sp_m, input logic [6:0] sp_f);
		logic [CMP_W-1:0] cw;
		cw = CMP_W'(c);
		if (cw < CMP_W'(lim_s))
			return sp_s;
		else if (cw < CMP_W'(lim_f))
			return sp_m;
		else
			return sp_f;
	endfunction

	assign up_inc    = hold_inc(up_hold_q);
	assign down_inc  = hold_inc(down_hold_q);
	assign left_inc  = hold_inc(left_hold_q);
	assign right_inc = hold_inc(right_hold_q);

	// Form the step of each axis; the first button of the axis wins
	always_comb begin
		logic [6:0] spd_y, spd_x;
		spd_y = speed_sel(up_btn ? up_inc : down_inc, slow_limit, fast_limit,
			speed_slow, speed_mid, speed_fast);
		spd_x = speed_sel(left_btn ? left_inc : right_inc, slow_limit, fast_limit,
			speed_slow, speed_mid, speed_fast);
		if (up_btn)
			step_y = 8'd0 - {1'b0, spd_y};
		else if (down_btn)
			step_y = {1'b0, spd_y};
		else
			step_y = 8'd0;
		if (left_btn)
			step_x = 8'd0 - {1'b0, spd_x};
		else if (right_btn)
			step_x = {1'b0, spd_x};
		else
			step_x = 8'd0;
	end

	// Advance the pressed counter, or clear both when the axis is released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_hold_q    <= '0;
			down_hold_q  <= '0;
			left_hold_q  <= '0;
			right_hold_q <= '0;
		end else if (update) begin
			if (up_btn) begin
				up_hold_q <= up_inc;
			end else if (down_btn) begin
				down_hold_q <= down_inc;
			end else begin
				up_hold_q   <= '0;
				down_hold_q <= '0;
			end
			if (left_btn) begin
				left_hold_q <= left_inc;
			end else if (right_btn) begin
				right_hold_q <= right_inc;
			end else begin
				left_hold_q  <= '0;
				right_hold_q <= '0;
			end
		end
	end

endmodule

FILE: src/bmm_trig.sv
`timescale 1ns / 1ps
// Circle-mode point: sine and cosine of the phase by a Horner chain in Q32,
// run on the shared multiplier under a small sequencer. Depends on bmm_pkg, bmm_mul.
module bmm_trig
	import bmm_pkg::*;
#(
	parameter int PHASE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [PHASE_BITS-1:0] phase,
	input  logic [6:0]            radius,
	output trig_sts_t             sts,
	output logic signed [7:0]     step_x,
	output logic signed [7:0]     step_y
);

	trig_state_t state_q, state_d;

	logic [1:0]  quad_q;
	logic        swap_q;
	logic [29:0] g_q;
	logic [31:0] x_q;
	logic [31:0] s_q;
	logic [32:0] t_q;
	logic [31:0] sin_q;
	logic [32:0] cos_q;
	logic [3:0]  step_q;
	logic signed [7:0] sx_q, sy_q;

	logic [32:0] op_a, op_b;
	logic [65:0] prod;

	logic [31:0] ang;
	logic [29:0] frac;
	logic        fold;
	logic [31:0] quot;
	logic [32:0] t_new;
	logic [32:0] c0, s0, mag_x, mag_y;
	logic        neg_x, neg_y;
	logic [6:0]  scaled;

	bmm_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	// Fold the phase into the first octant of its quadrant
	assign ang  = {phase, {(32-PHASE_BITS){1'b0}}};
	assign frac = ang[29:0];
	assign fold = frac > 30'h2000_0000;

	// Chain step: exact divide by multiply and shift
	assign quot  = 32'(prod >> (7'd32 + 7'(CHAIN_L[step_q])));
	assign t_new = ONE_Q32 - {1'b0, quot};

	// Map the magnitudes back to the quadrant
	assign c0     = swap_q ? {1'b0, sin_q} : cos_q;
	assign s0     = swap_q ? cos_q : {1'b0, sin_q};
	assign mag_x  = quad_q[0] ? s0 : c0;
	assign mag_y  = quad_q[0] ? c0 : s0;
	assign neg_x  = quad_q[1] ^ quad_q[0];
	assign neg_y  = quad_q[1];
	assign scaled = prod[38:32];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TR_IDLE:    if (start) state_d = TR_X_MUL;
			TR_X_MUL:   state_d = TR_X_GET;
			TR_X_GET:   state_d = TR_S_MUL;
			TR_S_MUL:   state_d = TR_S_GET;
			TR_S_GET:   state_d = TR_T_MUL;
			TR_T_MUL:   state_d = TR_D_MUL;
			TR_D_MUL:   state_d = TR_D_GET;
			TR_D_GET: begin
				if (step_q == SIN_LAST)
					state_d = TR_SIN_MUL;
				else if (step_q == COS_LAST)
					state_d = TR_SX_MUL;
				else
					state_d = TR_T_MUL;
			end
			TR_SIN_MUL: state_d = TR_SIN_GET;
			TR_SIN_GET: state_d = TR_T_MUL;
			TR_SX_MUL:  state_d = TR_SX_GET;
			TR_SX_GET:  state_d = TR_SY_MUL;
			TR_SY_MUL:  state_d = TR_SY_GET;
			TR_SY_GET:  state_d = TR_DONE;
			TR_DONE:    state_d = TR_IDLE;
			default:    state_d = TR_IDLE;
		endcase
	end

	// Operand select and status
	always_comb begin
		op_a     = '0;
		op_b     = '0;
		sts.busy = (state_q != TR_IDLE);
		sts.done = (state_q == TR_DONE);
		unique case (state_q)
			TR_X_MUL: begin
				op_a = 33'(g_q);
				op_b = 33'(TWO_PI_FRAC);
			end
			TR_S_MUL: begin
				op_a = {1'b0, x_q};
				op_b = {1'b0, x_q};
			end
			TR_T_MUL: begin
				op_a = {1'b0, s_q};
				op_b = t_q;
			end
			TR_D_MUL: begin
				op_a = {1'b0, prod[63:32]};
				op_b = CHAIN_M[step_q];
			end
			TR_SIN_MUL: begin
				op_a = {1'b0, x_q};
				op_b = t_q;
			end
			TR_SX_MUL: begin
				op_a = 33'(radius);
				op_b = mag_x;
			end
			TR_SY_MUL: begin
				op_a = 33'(radius);
				op_b = mag_y;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= TR_IDLE;
		else
			state_q <= state_d;
	end

	// Datapath registers, written per sequencer step
	always_ff @(posedge clk) begin
		case (state_q)
			TR_IDLE: begin
				if (start) begin
					quad_q <= ang[31:30];
					swap_q <= fold;
					g_q    <= fold ? 30'(31'h4000_0000 - {1'b0, frac}) : frac;
				end
			end
			TR_X_GET: begin
				x_q <= {g_q, 2'b00} + {1'b0, g_q, 1'b0} + prod[63:32];
			end
			TR_S_GET: begin
				s_q    <= prod[63:32];
				t_q    <= ONE_Q32;
				step_q <= '0;
			end
			TR_D_GET: begin
				if (step_q == COS_LAST) begin
					cos_q <= t_new;
				end else begin
					t_q <= t_new;
					if (step_q != SIN_LAST)
						step_q <= step_q + 4'd1;
				end
			end
			TR_SIN_GET: begin
				sin_q  <= prod[63:32];
				t_q    <= ONE_Q32;
				step_q <= step_q + 4'd1;
			end
			TR_SX_GET: begin
				sx_q <= neg_x ? 8'd0 - {1'b0, scaled} : {1'b0, scaled};
			end
			TR_SY_GET: begin
				sy_q <= neg_y ? 8'd0 - {1'b0, scaled} : {1'b0, scaled};
			end
			default: begin
			end
		endcase
	end

	assign step_x = sx_q;
	assign step_y = sy_q;

endmodule

FILE: src/button_mouse_mover_unit.sv
`timescale 1ns / 1ps
// Button mouse mover: one poll tick of five button levels in, one mouse step
// (step_x, step_y, circle_led) out. A tick in direction mode passes through
// accept, step and output load, and its result goes through the result register
// into the output register. The time of a tick in circle mode is set by the sine
// and cosine chain, which runs 27 multiplies through one shared 33x33 multiplier.
// The input side is ready again once the result sits in the output register;
// a result that is not taken stalls only the following tick. Depends on bmm_pkg,
// bmm_dir, bmm_trig.
module button_mouse_mover_unit
	import bmm_pkg::*;
#(
	parameter int PHASE_BITS = 16,
	parameter int HOLD_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// s_tdata: [0] up_pressed, [1] down_pressed, [2] left_pressed,
	//          [3] right_pressed, [4] mode_pressed, [7:5] zero
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,
	// m_tdata: [7:0] step_x, [15:8] step_y, [16] circle_led, [23:17] zero
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	top_state_t state_q, state_d;

	logic [15:0] slow_limit_q, fast_limit_q, phase_step_q;
	logic [6:0]  speed_slow_q, speed_mid_q, speed_fast_q, radius_q;

	logic [4:0]  btn_q;
	logic        circle_on_q, mode_held_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic signed [7:0] res_x_q, res_y_q;

	logic        out_valid_q;
	logic signed [7:0] out_x_q, out_y_q;
	logic        out_led_q;

	logic        in_xfer, out_free, cfg_wr;
	logic        trig_start, dir_update, load_out;
	logic        circle_next;
	trig_sts_t   trig_sts;
	logic signed [7:0] dir_x, dir_y, trig_x, trig_y;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	// Mode toggles on a press edge of the mode button
	assign circle_next = (btn_q[4] && !mode_held_q) ? !circle_on_q : circle_on_q;

	bmm_dir #(
		.HOLD_BITS (HOLD_BITS)
	) u_dir (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (dir_update),
		.up_btn     (btn_q[0]),
		.down_btn   (btn_q[1]),
		.left_btn   (btn_q[2]),
		.right_btn  (btn_q[3]),
		.slow_limit (slow_limit_q),
		.fast_limit (fast_limit_q),
		.speed_slow (speed_slow_q),
		.speed_mid  (speed_mid_q),
		.speed_fast (speed_fast_q),
		.step_x     (dir_x),
		.step_y     (dir_y)
	);

	bmm_trig #(
		.PHASE_BITS (PHASE_BITS)
	) u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (trig_start),
		.phase  (phase_q),
		.radius (radius_q),
		.sts    (trig_sts),
		.step_x (trig_x),
		.step_y (trig_y)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_xfer) state_d = circle_on_q ? ST_TRIG : ST_DIR;
			ST_DIR:  state_d = ST_DONE;
			ST_TRIG: if (trig_sts.done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		trig_start = (state_q == ST_IDLE) && s_tvalid && circle_on_q;
		dir_update = (state_q == ST_DIR);
		load_out   = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Hold the buttons of the accepted tick and the step formed for it
	always_ff @(posedge clk) begin
		if (in_xfer)
			btn_q <= s_tdata[4:0];
		if (dir_update) begin
			res_x_q <= dir_x;
			res_y_q <= dir_y;
		end else if (state_q == ST_TRIG && trig_sts.done) begin
			res_x_q <= trig_x;
			res_y_q <= trig_y;
		end
	end

	// Mode, mode button mark and circle phase advance at the end of a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circle_on_q <= 1'b0;
			mode_held_q <= 1'b0;
			phase_q     <= '0;
		end else if (load_out) begin
			circle_on_q <= circle_next;
			mode_held_q <= btn_q[4];
			if (circle_on_q)
				phase_q <= phase_q + PHASE_BITS'(phase_step_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q   <= res_x_q;
			out_y_q   <= res_y_q;
			out_led_q <= circle_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_led_q, out_y_q, out_x_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_limit_q <= RST_SLOW_LIMIT;
			fast_limit_q <= RST_FAST_LIMIT;
			speed_slow_q <= RST_SPEED_SLOW;
			speed_mid_q  <= RST_SPEED_MID;
			speed_fast_q <= RST_SPEED_FAST;
			radius_q     <= RST_RADIUS;
			phase_step_q <= RST_PHASE_STEP;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(paddr[4:2]))
				REG_SLOW_LIMIT: slow_limit_q <= pwdata[15:0];
				REG_FAST_LIMIT: fast_limit_q <= pwdata[15:0];
				REG_SPEED_SLOW: speed_slow_q <= pwdata[6:0];
				REG_SPEED_MID:  speed_mid_q  <= pwdata[6:0];
				REG_SPEED_FAST: speed_fast_q <= pwdata[6:0];
				REG_RADIUS:     radius_q     <= pwdata[6:0];
				REG_PHASE_STEP: phase_step_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Configuration reads
	always_comb begin
		unique case (cfg_reg_t'(paddr[4:2]))
			REG_SLOW_LIMIT: prdata = 32'(slow_limit_q);
			REG_FAST_LIMIT: prdata = 32'(fast_limit_q);
			REG_SPEED_SLOW: prdata = 32'(speed_slow_q);
			REG_SPEED_MID:  prdata = 32'(speed_mid_q);
			REG_SPEED_FAST: prdata = 32'(speed_fast_q);
			REG_RADIUS:     prdata = 32'(radius_q);
			REG_PHASE_STEP: prdata = 32'(phase_step_q);
			default:        prdata = '0;
		endcase
	end

endmodule

FILE: src/bmm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the button mouse mover, bound to the top level.
// Depends on bmm_pkg and button_mouse_mover_unit.
module bmm_checker
	import bmm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// Drop ready for the tick that was just taken
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Steps stay within +/-127 and the padding stays zero
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80)
			&& (m_tdata[23:17] == 7'd0))
		else $error("step out of range or padding set");

	// A new result only follows work on an accepted tick
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while idle");

endmodule

bind button_mouse_mover_unit bmm_checker u_bmm_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for button_mouse_mover_unit: button ticks in, mouse steps out.
// A clocked driver and monitor around the block; the expected steps come from a
// local fixed-point predictor. Depends on bmm_pkg and the block itself.
module tb_top;
	import bmm_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_TICKS  = 150;
	localparam int HOLD_TICKS   = 100;
	localparam logic [127:0] Q32_ONE   = 128'h1_0000_0000;
	localparam logic [127:0] TWO_PI_32 = 128'd26986075409;

	// button bits of one tick
	localparam logic [4:0] BTN_UP    = 5'b00001;
	localparam logic [4:0] BTN_DOWN  = 5'b00010;
	localparam logic [4:0] BTN_LEFT  = 5'b00100;
	localparam logic [4:0] BTN_RIGHT = 5'b01000;
	localparam logic [4:0] BTN_MODE  = 5'b10000;

	typedef struct packed {
		logic       led;
		logic [7:0] sy;
		logic [7:0] sx;
	} mouse_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// s_tdata: [0] up, [1] down, [2] left, [3] right, [4] mode, [7:5] zero
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// m_tdata: [7:0] step_x, [15:8] step_y, [16] circle_led, [23:17] zero
	logic [OUT_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	logic [4:0]  btn_queue[$];
	mouse_step_t step_queue[$];
	int err_count = 0;
	int cycles = 0;
	int in_count = 0;
	bit calm = 1'b0;
	int stall_left = 0;
	bit stall_done = 1'b0;

	// mirror of the configuration registers
	logic [15:0] cfg_slow = RST_SLOW_LIMIT;
	logic [15:0] cfg_fast = RST_FAST_LIMIT;
	logic [6:0]  cfg_spd_slow = RST_SPEED_SLOW;
	logic [6:0]  cfg_spd_mid = RST_SPEED_MID;
	logic [6:0]  cfg_spd_fast = RST_SPEED_FAST;
	logic [6:0]  cfg_radius = RST_RADIUS;
	logic [15:0] cfg_pstep = RST_PHASE_STEP;

	// predicted block state
	logic [15:0] up_cnt = '0, down_cnt = '0, left_cnt = '0, right_cnt = '0;
	logic        circle_on = 1'b0;
	logic        mode_held = 1'b0;
	logic [15:0] phase = '0;

	button_mouse_mover_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		if (err_count < 40) begin
			$display("ERROR cycle %0d: %s", cycles, msg);
		end
		err_count++;
	endtask

	function automatic logic [15:0] sat_inc(input logic [15:0] c);
		return (c == 16'hFFFF) ? c : c + 16'd1;
	endfunction

	function automatic logic [7:0] hold_speed(input logic [15:0] c, input bit neg);
		logic [6:0] spd;
		if (c < cfg_slow) spd = cfg_spd_slow;
		else if (c < cfg_fast) spd = cfg_spd_mid;
		else spd = cfg_spd_fast;
		return neg ? 8'd0 - {1'b0, spd} : {1'b0, spd};
	endfunction

	// Horner chain 1 - s/k (1 - s/k (...)) over the sine or cosine divisors
	function automatic logic [127:0] horner(input logic [127:0] sq, input bit cosine);
		logic [127:0] t;
		logic [127:0] k;
		int i;
		t = Q32_ONE;
		for (i = cosine ? 5 : 0; i <= (cosine ? 10 : 4); i++) begin
			case (i)
				0: k = 110;
				1: k = 72;
				2: k = 42;
				3: k = 20;
				4: k = 6;
				5: k = 132;
				6: k = 90;
				7: k = 56;
				8: k = 30;
				9: k = 12;
				default: k = 2;
			endcase
			t = Q32_ONE - (((sq * t) >> 32) / k);
		end
		return t;
	endfunction

	function automatic logic [7:0] scale_mag(input logic [127:0] mag, input bit neg);
		logic [127:0] prod;
		prod = ({121'd0, cfg_radius} * mag) >> 32;
		return neg ? 8'd0 - prod[7:0] : prod[7:0];
	endfunction

	// radius * (cos, sin) of the current phase, truncated toward zero
	task automatic circle_xy(output logic [7:0] sx, output logic [7:0] sy);
		logic [31:0] ang;
		logic [29:0] frac;
		logic fold;
		logic [127:0] g, xr, sq, sn, cs, c0, s0;
		ang = {phase, 16'h0000};
		frac = ang[29:0];
		fold = frac > 30'h2000_0000;
		g = fold ? 128'h4000_0000 - {98'd0, frac} : {98'd0, frac};
		xr = (g * TWO_PI_32) >> 32;
		sq = (xr * xr) >> 32;
		sn = (xr * horner(sq, 1'b0)) >> 32;
		cs = horner(sq, 1'b1);
		c0 = fold ? sn : cs;
		s0 = fold ? cs : sn;
		case (ang[31:30])
			2'd0: begin sx = scale_mag(c0, 1'b0); sy = scale_mag(s0, 1'b0); end
			2'd1: begin sx = scale_mag(s0, 1'b1); sy = scale_mag(c0, 1'b0); end
			2'd2: begin sx = scale_mag(c0, 1'b1); sy = scale_mag(s0, 1'b1); end
			default: begin sx = scale_mag(s0, 1'b0); sy = scale_mag(c0, 1'b1); end
		endcase
	endtask

	// Advance the predicted state by one tick and queue the step it gives
	task automatic move_mouse(input logic [4:0] btn);
		mouse_step_t st;
		st = '0;
		if (circle_on) begin
			circle_xy(st.sx, st.sy);
			phase = phase + cfg_pstep;
		end else begin
			if (btn & BTN_UP) begin
				up_cnt = sat_inc(up_cnt);
				st.sy = hold_speed(up_cnt, 1'b1);
			end else if (btn & BTN_DOWN) begin
				down_cnt = sat_inc(down_cnt);
				st.sy = hold_speed(down_cnt, 1'b0);
			end else begin
				up_cnt = '0;
				down_cnt = '0;
			end
			if (btn & BTN_LEFT) begin
				left_cnt = sat_inc(left_cnt);
				st.sx = hold_speed(left_cnt, 1'b1);
			end else if (btn & BTN_RIGHT) begin
				right_cnt = sat_inc(right_cnt);
				st.sx = hold_speed(right_cnt, 1'b0);
			end else begin
				left_cnt = '0;
				right_cnt = '0;
			end
		end
		if ((btn & BTN_MODE) && !mode_held) begin
			circle_on = !circle_on;
			mode_held = 1'b1;
		end else if (!(btn & BTN_MODE)) begin
			mode_held = 1'b0;
		end
		st.led = circle_on;
		step_queue.push_back(st);
	endtask

	// Driver: offer queued ticks, hold each until its transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				move_mouse(s_tdata[4:0]);
				in_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (btn_queue.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
					s_tdata <= {3'b000, btn_queue.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready: random idling plus one long hold-off to back up the input
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!stall_done && in_count >= 300) begin
			stall_done <= 1'b1;
			stall_left <= 400;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 23);
		end
	end

	// Monitor: compare each result transfer with the oldest expected step
	always @(posedge clk) begin
		mouse_step_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (step_queue.size() == 0) begin
				flag_error($sformatf("step %h with no tick pending", m_tdata));
			end else begin
				want = step_queue.pop_front();
				if (m_tdata[7:0] !== want.sx)
					flag_error($sformatf("step_x %h, want %h", m_tdata[7:0], want.sx));
				if (m_tdata[15:8] !== want.sy)
					flag_error($sformatf("step_y %h, want %h", m_tdata[15:8], want.sy));
				if (m_tdata[16] !== want.led)
					flag_error($sformatf("circle_led %b, want %b", m_tdata[16], want.led));
				if (m_tdata[23:17] !== 7'd0)
					flag_error($sformatf("padding bits %h not zero", m_tdata[23:17]));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic apb_write(input cfg_reg_t r, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_SLOW_LIMIT: cfg_slow = v[15:0];
			REG_FAST_LIMIT: cfg_fast = v[15:0];
			REG_SPEED_SLOW: cfg_spd_slow = v[6:0];
			REG_SPEED_MID:  cfg_spd_mid = v[6:0];
			REG_SPEED_FAST: cfg_spd_fast = v[6:0];
			REG_RADIUS:     cfg_radius = v[6:0];
			default:        cfg_pstep = v[15:0];
		endcase
	endtask

	task automatic apply_setting(input int slow, input int fast, input int ss, input int sm,
			input int sf, input int rad, input int ps);
		apb_write(REG_SLOW_LIMIT, slow);
		apb_write(REG_FAST_LIMIT, fast);
		apb_write(REG_SPEED_SLOW, ss);
		apb_write(REG_SPEED_MID, sm);
		apb_write(REG_SPEED_FAST, sf);
		apb_write(REG_RADIUS, rad);
		apb_write(REG_PHASE_STEP, ps);
	endtask

	// Wait until every queued tick has gone in and every step has come out
	task automatic drain();
		do begin
			@(posedge clk);
		end while (btn_queue.size() != 0 || s_tvalid || step_queue.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Mostly held directions and clean mode presses, some noise
	task automatic fill_random(input int n);
		int cnt, kind, len, i;
		logic [4:0] dirs;
		cnt = 0;
		while (cnt < n) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				dirs = 5'($urandom_range(15));
				len = $urandom_range(1, 60);
				for (i = 0; i < len; i++) begin
					if ($urandom_range(19) == 0) btn_queue.push_back(5'($urandom_range(15)));
					else btn_queue.push_back(dirs);
				end
			end else if (kind < 75) begin
				len = $urandom_range(1, 3);
				for (i = 0; i < len; i++) btn_queue.push_back(BTN_MODE | 5'($urandom_range(15)));
				btn_queue.push_back(5'($urandom_range(15)));
				len = len + 1;
			end else if (kind < 90) begin
				len = $urandom_range(1, 4);
				for (i = 0; i < len; i++) btn_queue.push_back(5'd0);
			end else begin
				len = $urandom_range(1, 8);
				for (i = 0; i < len; i++) btn_queue.push_back(5'($urandom_range(31)));
			end
			cnt = cnt + len;
		end
	endtask

	initial begin
		int p, i, lo;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks at reset settings: axis priority, release, mode edges
		btn_queue.push_back(5'd0);
		btn_queue.push_back(BTN_UP);
		btn_queue.push_back(BTN_UP);
		btn_queue.push_back(BTN_DOWN);
		btn_queue.push_back(BTN_UP | BTN_DOWN);
		btn_queue.push_back(5'd0);
		btn_queue.push_back(BTN_LEFT);
		btn_queue.push_back(BTN_RIGHT);
		btn_queue.push_back(BTN_LEFT | BTN_RIGHT);
		btn_queue.push_back(BTN_UP | BTN_DOWN | BTN_LEFT | BTN_RIGHT);
		btn_queue.push_back(5'd0);
		btn_queue.push_back(BTN_MODE);
		btn_queue.push_back(BTN_MODE);
		btn_queue.push_back(BTN_UP | BTN_DOWN | BTN_LEFT | BTN_RIGHT);
		btn_queue.push_back(5'd0);
		btn_queue.push_back(BTN_MODE | BTN_UP | BTN_LEFT);
		btn_queue.push_back(BTN_UP | BTN_LEFT);
		btn_queue.push_back(BTN_MODE);
		btn_queue.push_back(5'd0);
		btn_queue.push_back(BTN_MODE);
		btn_queue.push_back(5'd0);
		btn_queue.push_back(5'b11111);
		btn_queue.push_back(5'd0);
		fill_random(PHASE_TICKS);
		drain();

		// extremes, limits out of order, octant-aligned phase, then random settings
		for (p = 1; p < 8; p++) begin
			case (p)
				1: apply_setting(65535, 65535, 127, 127, 127, 127, 65535);
				2: apply_setting(1, 1, 0, 0, 0, 0, 0);
				3: apply_setting(40, 8, 7, 70, 127, 127, 16'h2000);
				default: begin
					lo = $urandom_range(1, 30);
					apply_setting(lo, lo + $urandom_range(0, 40), $urandom_range(127),
						$urandom_range(127), $urandom_range(127), $urandom_range(127),
						$urandom_range(65535));
				end
			endcase
			fill_random(PHASE_TICKS);
			drain();
		end

		// long unbroken hold across both speed limits, no idling
		apply_setting(20, 60, 3, 60, 127, 5, 77);
		calm = 1'b1;
		if (circle_on) begin
			btn_queue.push_back(BTN_MODE);
			btn_queue.push_back(5'd0);
		end
		for (i = 0; i < HOLD_TICKS; i++) begin
			btn_queue.push_back(BTN_UP | BTN_LEFT | ($urandom_range(1) ? BTN_DOWN : 5'd0) |
				($urandom_range(1) ? BTN_RIGHT : 5'd0));
		end
		btn_queue.push_back(BTN_DOWN | BTN_RIGHT);
		btn_queue.push_back(BTN_UP | BTN_LEFT);
		btn_queue.push_back(5'd0);
		btn_queue.push_back(BTN_UP | BTN_LEFT);
		drain();
		calm = 1'b0;

		repeat (60) @(posedge clk);
		if (step_queue.size() != 0)
			flag_error($sformatf("%0d expected steps never came out", step_queue.size()));
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
